// ===== hdl/calibration_segment_interpolator_defines.svh =====
// ----------------------------------------------------------------------------
// calibration_segment_interpolator_defines.svh
// Assertion macros for the calibration segment interpolator.
// They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CALIBRATION_SEGMENT_INTERPOLATOR_DEFINES_SVH
`define CALIBRATION_SEGMENT_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle
`define CSI_ASSERT_SAME(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("csi assertion failed");

// Check that a condition implies another in the next cycle
`define CSI_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("csi assertion failed");

`else

`define CSI_ASSERT_SAME(label, clk, rst_n, cond, expr)
`define CSI_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// ===== hdl/csi_pkg.sv =====
// ----------------------------------------------------------------------------
// csi_pkg
// Shared widths, calibration ROM, controller state and command/status types
// of the calibration segment interpolator.
// ----------------------------------------------------------------------------
package csi_pkg;

	// field widths
	localparam int TARGET_W = 10;
	localparam int DUTY_W   = 8;
	localparam int BLEND_W  = 10;

	localparam logic [BLEND_W-1:0] BLEND_SCALE = 10'd1000;

	// divider: numerator covers 1023 * 1000, remainder one bit over the divisor
	localparam int NUM_W           = 20;
	localparam int REM_W           = TARGET_W + 1;
	localparam int DIV_BITS_PER_CY = 2;
	localparam int DIV_CYCLES      = NUM_W / DIV_BITS_PER_CY;
	localparam int DIV_CNT_W       = $clog2(DIV_CYCLES);

	// calibration ROM
	localparam int DEFAULT_POINT_COUNT = 12;
	localparam int ROM_POINTS          = 12;
	localparam int ROM_IDX_W           = $clog2(ROM_POINTS);

	typedef logic [ROM_IDX_W-1:0] rom_idx_t;

	localparam logic [DUTY_W-1:0] ROM_DUTY [ROM_POINTS] = '{
		8'd0, 8'd15, 8'd35, 8'd55, 8'd75, 8'd95,
		8'd115, 8'd135, 8'd155, 8'd175, 8'd195, 8'd225
	};

	localparam logic [TARGET_W-1:0] ROM_SPEED [ROM_POINTS] = '{
		10'd0, 10'd0, 10'd0, 10'd0, 10'd20, 10'd60,
		10'd60, 10'd60, 10'd80, 10'd80, 10'd80, 10'd90
	};

	// points past the ROM repeat its last entry
	function automatic logic [DUTY_W-1:0] pt_duty(input int unsigned i);
		logic [DUTY_W-1:0] d;
		if (i < ROM_POINTS) begin
			d = ROM_DUTY[rom_idx_t'(i)];
		end else begin
			d = ROM_DUTY[rom_idx_t'(ROM_POINTS - 1)];
		end
		return d;
	endfunction

	function automatic logic [TARGET_W-1:0] pt_speed(input int unsigned i);
		logic [TARGET_W-1:0] s;
		if (i < ROM_POINTS) begin
			s = ROM_SPEED[rom_idx_t'(i)];
		end else begin
			s = ROM_SPEED[rom_idx_t'(ROM_POINTS - 1)];
		end
		return s;
	endfunction

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SEARCH,
		ST_DIVIDE,
		ST_FINISH,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic end_low;
		logic end_high;
		logic seg_step;
		logic seg_take;
		logic set_none;
		logic div_step;
		logic div_finish;
	} csi_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic at_low;
		logic at_high;
		logic seg_hit;
		logic seg_last;
		logic div_last;
	} csi_status_t;

endpackage

// ===== hdl/csi_datapath.sv =====
// ----------------------------------------------------------------------------
// csi_datapath
// Target register, segment search index, numerator and an iterative
// restoring divider that retires two quotient bits per cycle.
// ----------------------------------------------------------------------------
module csi_datapath #(
	parameter int POINT_COUNT = csi_pkg::DEFAULT_POINT_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  csi_pkg::csi_cmd_t             cmd,
	output csi_pkg::csi_status_t          status,
	input  logic [csi_pkg::TARGET_W-1:0]  target_speed,
	output logic [csi_pkg::DUTY_W-1:0]    lower_duty,
	output logic [csi_pkg::DUTY_W-1:0]    upper_duty,
	output logic [csi_pkg::BLEND_W-1:0]   blend
);

	localparam int IDX_W = $clog2(POINT_COUNT);
	localparam int LAST  = POINT_COUNT - 1;

	logic [csi_pkg::TARGET_W-1:0]  target_q;
	logic [IDX_W-1:0]              idx_q;
	logic [csi_pkg::NUM_W-1:0]     num_q;
	logic [csi_pkg::REM_W-1:0]     rem_q;
	logic [csi_pkg::TARGET_W-1:0]  den_q;
	logic [csi_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [csi_pkg::DUTY_W-1:0]    lower_duty_q;
	logic [csi_pkg::DUTY_W-1:0]    upper_duty_q;
	logic [csi_pkg::BLEND_W-1:0]   blend_q;

	logic [IDX_W-1:0]              idx_prev;
	logic [csi_pkg::TARGET_W-1:0]  v0;
	logic [csi_pkg::TARGET_W-1:0]  v1;
	logic [csi_pkg::TARGET_W-1:0]  diff;
	logic [csi_pkg::NUM_W-1:0]     numer;
	logic [csi_pkg::NUM_W-1:0]     num_nx;
	logic [csi_pkg::REM_W-1:0]     rem_nx;

	// current segment end points
	assign idx_prev = idx_q - 1'b1;
	assign v0       = csi_pkg::pt_speed(int'(idx_prev));
	assign v1       = csi_pkg::pt_speed(int'(idx_q));
	assign diff     = (target_q >= v0) ? (target_q - v0) : '0;
	assign numer    = csi_pkg::NUM_W'(diff) * csi_pkg::NUM_W'(csi_pkg::BLEND_SCALE);

	// status towards the controller
	assign status.at_low   = target_q <= csi_pkg::pt_speed(0);
	assign status.at_high  = target_q >= csi_pkg::pt_speed(LAST);
	assign status.seg_hit  = (target_q <= v1) && (v1 > v0);
	assign status.seg_last = idx_q == IDX_W'(LAST);
	assign status.div_last = div_cnt_q == csi_pkg::DIV_CNT_W'(csi_pkg::DIV_CYCLES - 1);

	// two restoring division steps
	always_comb begin
		num_nx = num_q;
		rem_nx = rem_q;
		for (int k = 0; k < csi_pkg::DIV_BITS_PER_CY; k++) begin
			rem_nx = {rem_nx[csi_pkg::REM_W-2:0], num_nx[csi_pkg::NUM_W-1]};
			num_nx = {num_nx[csi_pkg::NUM_W-2:0], 1'b0};
			if (rem_nx >= csi_pkg::REM_W'(den_q)) begin
				rem_nx    = rem_nx - csi_pkg::REM_W'(den_q);
				num_nx[0] = 1'b1;
			end
		end
	end

	// search index and divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			div_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				idx_q <= IDX_W'(1);
			end else if (cmd.seg_step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.seg_take) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

	// hold target, divider words and results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			target_q <= target_speed;
		end
		if (cmd.seg_take) begin
			num_q        <= numer;
			rem_q        <= '0;
			den_q        <= v1 - v0;
			lower_duty_q <= csi_pkg::pt_duty(int'(idx_prev));
			upper_duty_q <= csi_pkg::pt_duty(int'(idx_q));
		end else if (cmd.div_step) begin
			num_q <= num_nx;
			rem_q <= rem_nx;
		end
		if (cmd.end_low) begin
			lower_duty_q <= csi_pkg::pt_duty(0);
			upper_duty_q <= csi_pkg::pt_duty(0);
			blend_q      <= '0;
		end else if (cmd.end_high) begin
			lower_duty_q <= csi_pkg::pt_duty(LAST);
			upper_duty_q <= csi_pkg::pt_duty(LAST);
			blend_q      <= '0;
		end else if (cmd.set_none) begin
			lower_duty_q <= '0;
			upper_duty_q <= '0;
			blend_q      <= '0;
		end else if (cmd.div_finish) begin
			// cap the quotient at full scale
			if (num_q > csi_pkg::NUM_W'(csi_pkg::BLEND_SCALE)) begin
				blend_q <= csi_pkg::BLEND_SCALE;
			end else begin
				blend_q <= num_q[csi_pkg::BLEND_W-1:0];
			end
		end
	end

	assign lower_duty = lower_duty_q;
	assign upper_duty = upper_duty_q;
	assign blend      = blend_q;

endmodule

// ===== hdl/csi_ctrl.sv =====
// ----------------------------------------------------------------------------
// csi_ctrl
// Controller of the calibration segment interpolator: end point check,
// one segment per cycle search, divider sequencing and result strobe.
// ----------------------------------------------------------------------------
`include "calibration_segment_interpolator_defines.svh"

module csi_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	output csi_pkg::csi_cmd_t    cmd,
	input  csi_pkg::csi_status_t status
);

	csi_pkg::state_t state_q;
	csi_pkg::state_t state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csi_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		busy     = 1'b1;
		done     = 1'b0;
		case (state_q)
			csi_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_nx = csi_pkg::ST_CHECK;
				end
			end
			csi_pkg::ST_CHECK: begin
				if (status.at_low) begin
					cmd.end_low = 1'b1;
					state_nx    = csi_pkg::ST_DONE;
				end else if (status.at_high) begin
					cmd.end_high = 1'b1;
					state_nx     = csi_pkg::ST_DONE;
				end else begin
					state_nx = csi_pkg::ST_SEARCH;
				end
			end
			csi_pkg::ST_SEARCH: begin
				if (status.seg_hit) begin
					cmd.seg_take = 1'b1;
					state_nx     = csi_pkg::ST_DIVIDE;
				end else if (status.seg_last) begin
					cmd.set_none = 1'b1;
					state_nx     = csi_pkg::ST_DONE;
				end else begin
					cmd.seg_step = 1'b1;
				end
			end
			csi_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_nx = csi_pkg::ST_FINISH;
				end
			end
			csi_pkg::ST_FINISH: begin
				cmd.div_finish = 1'b1;
				state_nx       = csi_pkg::ST_DONE;
			end
			csi_pkg::ST_DONE: begin
				done     = 1'b1;
				state_nx = csi_pkg::ST_IDLE;
			end
			default: begin
				state_nx = csi_pkg::ST_IDLE;
			end
		endcase
	end

	// result strobe only while busy, one cycle wide, never right after a transfer
	`CSI_ASSERT_SAME(a_done_busy, clk, arst_n, done, busy)
	`CSI_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`CSI_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	`CSI_ASSERT_SAME(a_div_only_dividing, clk, arst_n, cmd.div_step, !cmd.load && !done)

endmodule

// ===== hdl/calibration_segment_interpolator.sv =====
// ----------------------------------------------------------------------------
// calibration_segment_interpolator
// Piecewise linear lookup of a target speed in a fixed calibration table,
// giving the segment's two duties and the blend position in thousandths.
// ----------------------------------------------------------------------------
// Sequence: after the transfer the end points are checked; an end point target
// goes straight to done, otherwise the segments are searched in turn, the
// two-bit-per-cycle divider runs, the quotient is capped and then presented.
// busy stays high from the transfer through done; a new target is taken only in idle.
// The result is shown for one cycle with done; the receiver cannot stall it.
// Reset clears the controller to idle; result registers are not reset.
module calibration_segment_interpolator #(
	parameter int POINT_COUNT = csi_pkg::DEFAULT_POINT_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [csi_pkg::TARGET_W-1:0]  target_speed,
	output logic                          done,
	output logic [csi_pkg::DUTY_W-1:0]    lower_duty,
	output logic [csi_pkg::DUTY_W-1:0]    upper_duty,
	output logic [csi_pkg::BLEND_W-1:0]   blend
);

	csi_pkg::csi_cmd_t    cmd;
	csi_pkg::csi_status_t status;

	// sequence the search and divide
	csi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.status (status)
	);

	// table lookup and divider
	csi_datapath #(
		.POINT_COUNT (POINT_COUNT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.target_speed (target_speed),
		.lower_duty   (lower_duty),
		.upper_duty   (upper_duty),
		.blend        (blend)
	);

endmodule
